// File: rtl/esd_pkg.sv
// Shared types, character constants and helper functions for the escape
// sequence decoder. No dependencies.
`timescale 1ns / 1ps

package esd_pkg;

    // Decoder phase codes
    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_BSL   = 3'd1,
        PH_HX1   = 3'd2,
        PH_HX2   = 3'd3,
        PH_PC1   = 3'd4,
        PH_PC2   = 3'd5,
        PH_COPY  = 3'd6
    } phase_t;

    localparam int unsigned RUN_MAX = 4;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned IDX_W   = 2;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_ZERO = 8'h30;

    // One decoded run: up to four bytes, count zero means nothing to send
    typedef struct packed {
        logic [CNT_W-1:0]           count;
        logic [RUN_MAX-1:0][7:0]    bytes;
    } run_t;

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - 8'h30;
                return {1'b1, d[3:0]};
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                d = c - 8'h37;
                return {1'b1, d[3:0]};
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                d = c - 8'h57;
                return {1'b1, d[3:0]};
            end
            return 5'd0;
        end
    endfunction

    // {valid, byte} of a single-character C escape
    function automatic logic [8:0] simple_esc(input logic [7:0] c);
        begin
            case (c)
                8'h27:   return {1'b1, 8'h27};
                8'h22:   return {1'b1, 8'h22};
                8'h3F:   return {1'b1, 8'h3F};
                8'h5C:   return {1'b1, 8'h5C};
                8'h61:   return {1'b1, 8'h07};
                8'h62:   return {1'b1, 8'h08};
                8'h66:   return {1'b1, 8'h0C};
                8'h6E:   return {1'b1, 8'h0A};
                8'h72:   return {1'b1, 8'h0D};
                8'h74:   return {1'b1, 8'h09};
                8'h76:   return {1'b1, 8'h0B};
                default: return 9'd0;
            endcase
        end
    endfunction

endpackage

// File: rtl/esd_decode.sv
// Escape decoder: phase and held-digit registers plus the combinational
// decode of one source byte into a run of up to four bytes. Uses esd_pkg.
`timescale 1ns / 1ps

module esd_decode
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      in_byte,
    input  logic            accept,
    input  logic            escape_style,
    output esd_pkg::run_t   run
);

    esd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      held_reg, held_next;

    logic [4:0]      hx_c, hx_h;
    logic [8:0]      smp;
    logic [7:0]      hval;
    logic            is_pct;
    logic [1:0]      base;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= esd_pkg::PH_PLAIN;
            held_reg  <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // Decode of one byte
    always_comb
    begin
        hx_c   = esd_pkg::hex_val(in_byte);
        hx_h   = esd_pkg::hex_val(held_reg);
        smp    = esd_pkg::simple_esc(in_byte);
        hval   = {hx_h[3:0], hx_c[3:0]};
        is_pct = (phase_reg == esd_pkg::PH_PC1) || (phase_reg == esd_pkg::PH_PC2);
        // bytes taken by the escape introducer
        base   = is_pct ? 2'd1 : 2'd2;

        phase_next = esd_pkg::PH_PLAIN;
        held_next  = held_reg;
        run.count  = '0;
        run.bytes  = '0;

        // introducer prefix for hex escapes
        if (is_pct)
            run.bytes[0] = esd_pkg::CH_PCT;
        else
        begin
            run.bytes[0] = esd_pkg::CH_BSL;
            run.bytes[1] = esd_pkg::CH_X;
        end

        unique case (phase_reg)
            esd_pkg::PH_BSL:
            begin
                if (in_byte == esd_pkg::CH_NUL)
                begin
                    run.bytes[0] = esd_pkg::CH_BSL;
                    run.bytes[1] = esd_pkg::CH_NUL;
                    run.count    = 3'd2;
                    held_next    = 8'h00;
                end
                else if (smp[8])
                begin
                    run.bytes[0] = smp[7:0];
                    run.count    = 3'd1;
                end
                else if (in_byte == esd_pkg::CH_X)
                    phase_next = esd_pkg::PH_HX1;
                else
                begin
                    run.bytes[0] = esd_pkg::CH_BSL;
                    run.bytes[1] = in_byte;
                    run.count    = 3'd2;
                end
            end
            esd_pkg::PH_HX1,
            esd_pkg::PH_PC1:
            begin
                if (in_byte == esd_pkg::CH_NUL)
                begin
                    run.bytes[base] = esd_pkg::CH_NUL;
                    run.count       = {1'b0, base} + 3'd1;
                    held_next       = 8'h00;
                end
                else if (hx_c[4])
                begin
                    held_next  = in_byte;
                    phase_next = is_pct ? esd_pkg::PH_PC2 : esd_pkg::PH_HX2;
                end
                else
                begin
                    run.bytes[base] = in_byte;
                    run.count       = {1'b0, base} + 3'd1;
                    phase_next      = esd_pkg::PH_COPY;
                end
            end
            esd_pkg::PH_HX2,
            esd_pkg::PH_PC2:
            begin
                held_next = 8'h00;
                if (hx_h[4] && hx_c[4])
                begin
                    // a zero value comes out as backslash and '0'
                    if (hval == 8'h00)
                    begin
                        run.bytes[0] = esd_pkg::CH_BSL;
                        run.bytes[1] = esd_pkg::CH_ZERO;
                        run.count    = 3'd2;
                    end
                    else
                    begin
                        run.bytes[0] = hval;
                        run.count    = 3'd1;
                    end
                end
                else
                begin
                    // introducer, both digits; a NUL here is the terminator
                    run.bytes[base]        = held_reg;
                    run.bytes[base + 2'd1] = in_byte;
                    run.count              = {1'b0, base} + 3'd2;
                end
            end
            esd_pkg::PH_COPY:
            begin
                run.bytes[0] = in_byte;
                run.count    = 3'd1;
                if (in_byte == esd_pkg::CH_NUL)
                    held_next = 8'h00;
            end
            default:
            begin
                if (in_byte == esd_pkg::CH_NUL)
                begin
                    run.bytes[0] = esd_pkg::CH_NUL;
                    run.count    = 3'd1;
                    held_next    = 8'h00;
                end
                else if (!escape_style && in_byte == esd_pkg::CH_BSL)
                    phase_next = esd_pkg::PH_BSL;
                else if (escape_style && in_byte == esd_pkg::CH_PCT)
                    phase_next = esd_pkg::PH_PC1;
                else
                begin
                    run.bytes[0] = in_byte;
                    run.count    = 3'd1;
                end
            end
        endcase
    end

endmodule

// File: rtl/esd_run_buf.sv
// Result register for one decoded run, sent out one byte per cycle while
// out_ready is high, with the last byte of the run flagged. Uses esd_pkg.
`timescale 1ns / 1ps

module esd_run_buf
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  esd_pkg::run_t   run,
    output logic            space,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    logic                                 valid_reg;
    logic [esd_pkg::CNT_W-1:0]            cnt_reg;
    logic [esd_pkg::IDX_W-1:0]            idx_reg;
    logic [esd_pkg::RUN_MAX-1:0][7:0]     bytes_reg;
    logic                                 done;

    assign out_valid = valid_reg;
    assign out_byte  = bytes_reg[idx_reg];
    assign out_last  = ({1'b0, idx_reg} + 3'd1) == cnt_reg;
    assign done      = valid_reg && out_ready && out_last;
    // free now, or the final byte leaves this cycle
    assign space     = !valid_reg || done;

    // Control: run valid and byte index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
            cnt_reg   <= run.count;
        end
        else if (done)
            valid_reg <= 1'b0;
        else if (valid_reg && out_ready)
            idx_reg <= idx_reg + 2'd1;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
            bytes_reg <= run.bytes;
    end

endmodule

// File: rtl/escape_sequence_decoder_core.sv
// Top level of the escape sequence decoder: configuration register,
// stream handshakes, decoder and output run buffer. Uses esd_pkg.
`timescale 1ns / 1ps

// Takes one string byte per item and returns the decoded bytes, one per
// output item, with tlast on the final byte caused by each input item. A
// zero byte ends the string and yields a zero terminator; escapes are C
// backslash style or percent-hex style, chosen by cfg_data (0 = C, 1 =
// percent), which the user must write only while the block is idle; the
// block does not enforce this. Rate: one input byte per cycle whenever
// each item yields at most one output byte and the output is not stalled;
// a larger item (up to four bytes) holds off the next input until the run
// buffer sends its last byte. Items that only open an escape emit nothing.
module escape_sequence_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,        // [0] escape_style
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [7:0] out_byte
    output logic        m_axis_tlast     // run_last
);

    logic           escape_style_reg;
    logic           in_accept;
    logic           space;
    esd_pkg::run_t  run;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            escape_style_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            escape_style_reg <= cfg_data;
    end

    // Input handshake
    assign s_axis_tready = space;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    esd_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_byte      (s_axis_tdata),
        .accept       (in_accept),
        .escape_style (escape_style_reg),
        .run          (run)
    );

    esd_run_buf u_run_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_accept && (run.count != '0)),
        .run       (run),
        .space     (space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // An input item is taken only when no run is pending or its end leaves now
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (!m_axis_tvalid || (m_axis_tready && m_axis_tlast)))
        else $error("input taken while a run is still pending");

    // A zero byte is only ever the terminator, which closes its run
    a_nul_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata == 8'h00) |-> m_axis_tlast)
        else $error("zero byte not at end of run");

    // A terminator input always produces output in the next cycle
    a_nul_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tdata == 8'h00) |=> m_axis_tvalid)
        else $error("terminator produced no output");
`endif

endmodule

// File: tb/sv/tb_escape_sequence_decoder_core.sv
// Self-checking testbench for escape_sequence_decoder_core: random-stall stream driver,
// output monitor and a byte-level predictor of the unescaping rules. Uses esd_pkg.
`timescale 1ns / 1ps

module tb_escape_sequence_decoder_core;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned IDLE_PCT     = 19;
    localparam int unsigned PHASE_ITEMS  = 34;
    localparam int unsigned SETTLE_CYCLES = 8;

    // Style register values
    localparam logic STYLE_C   = 1'b0;
    localparam logic STYLE_PCT = 1'b1;

    // One expected output item
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dec_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;    // [7:0] in_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic       m_axis_tlast;            // run_last

    escape_sequence_decoder_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Source bytes waiting to be sent, decoded bytes waiting to arrive
    logic [7:0] string_q[$];
    dec_byte_t  decoded_q[$];
    logic [7:0] run_buf[$];

    // Predictor state
    logic              style_bit = STYLE_C;
    esd_pkg::phase_t   dec_phase = esd_pkg::PH_PLAIN;
    logic [7:0]        held_digit = 8'h00;

    logic        steady = 1'b0;
    bit          byte_taken = 1'b0;
    bit          presenting = 1'b0;
    int unsigned err_cnt = 0;
    int unsigned fed_cnt = 0;
    int unsigned out_cnt = 0;
    int unsigned cfg_cnt = 0;
    int unsigned queued_cnt = 0;
    int unsigned cycle_cnt = 0;

    // Clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor helpers
    // ---------------------------------------------------------------
    function automatic bit is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    // Letters have low nibble 1..6 for A..F / a..f
    function automatic logic [3:0] nib_of(input logic [7:0] c);
        if (c <= 8'h39)
            return c[3:0];
        return c[3:0] + 4'd9;
    endfunction

    // {hit, byte} for the one-character C escapes
    function automatic logic [8:0] c_escape(input logic [7:0] c);
        case (c)
            8'h27, 8'h22, 8'h3F, 8'h5C: return {1'b1, c};   // ' " ? backslash
            8'h61:   return {1'b1, 8'h07};                   // a -> bell
            8'h62:   return {1'b1, 8'h08};                   // b -> backspace
            8'h66:   return {1'b1, 8'h0C};                   // f -> form feed
            8'h6E:   return {1'b1, 8'h0A};                   // n -> line feed
            8'h72:   return {1'b1, 8'h0D};                   // r -> carriage return
            8'h74:   return {1'b1, 8'h09};                   // t -> tab
            8'h76:   return {1'b1, 8'h0B};                   // v -> vertical tab
            default: return 9'd0;
        endcase
    endfunction

    task automatic put(input logic [7:0] b);
        run_buf.push_back(b);
    endtask

    // Escape introducer copied back verbatim
    task automatic put_intro(input logic pct);
        if (pct)
            put(esd_pkg::CH_PCT);
        else
        begin
            put(esd_pkg::CH_BSL);
            put(esd_pkg::CH_X);
        end
    endtask

    task automatic end_string();
        put(esd_pkg::CH_NUL);
        dec_phase  = esd_pkg::PH_PLAIN;
        held_digit = 8'h00;
    endtask

    // Expected decoded bytes for one accepted source byte
    task automatic unescape_byte(input logic [7:0] c);
        logic [8:0] m;
        logic       pct;
        logic [7:0] v;
        run_buf.delete();
        case (dec_phase)
            esd_pkg::PH_BSL:
            begin
                m = c_escape(c);
                dec_phase = esd_pkg::PH_PLAIN;
                if (c == esd_pkg::CH_NUL)
                begin
                    put(esd_pkg::CH_BSL);
                    end_string();
                end
                else if (m[8])
                    put(m[7:0]);
                else if (c == esd_pkg::CH_X)
                    dec_phase = esd_pkg::PH_HX1;
                else
                begin
                    put(esd_pkg::CH_BSL);
                    put(c);
                end
            end
            esd_pkg::PH_HX1, esd_pkg::PH_PC1:
            begin
                pct = (dec_phase == esd_pkg::PH_PC1);
                if (c == esd_pkg::CH_NUL)
                begin
                    put_intro(pct);
                    end_string();
                end
                else if (is_hex(c))
                begin
                    held_digit = c;
                    dec_phase  = pct ? esd_pkg::PH_PC2 : esd_pkg::PH_HX2;
                end
                else
                begin
                    // bad first digit: the byte after it passes through untouched
                    put_intro(pct);
                    put(c);
                    dec_phase = esd_pkg::PH_COPY;
                end
            end
            esd_pkg::PH_HX2, esd_pkg::PH_PC2:
            begin
                pct = (dec_phase == esd_pkg::PH_PC2);
                if (is_hex(held_digit) && is_hex(c))
                begin
                    v = {nib_of(held_digit), nib_of(c)};
                    // a zero value must not end the string early
                    if (v == 8'h00)
                    begin
                        put(esd_pkg::CH_BSL);
                        put(esd_pkg::CH_ZERO);
                    end
                    else
                        put(v);
                    dec_phase  = esd_pkg::PH_PLAIN;
                    held_digit = 8'h00;
                end
                else
                begin
                    put_intro(pct);
                    put(held_digit);
                    if (c == esd_pkg::CH_NUL)
                        end_string();
                    else
                    begin
                        put(c);
                        dec_phase  = esd_pkg::PH_PLAIN;
                        held_digit = 8'h00;
                    end
                end
            end
            esd_pkg::PH_COPY:
            begin
                if (c == esd_pkg::CH_NUL)
                    end_string();
                else
                begin
                    put(c);
                    dec_phase = esd_pkg::PH_PLAIN;
                end
            end
            default:
            begin
                // style is only looked at here
                dec_phase = esd_pkg::PH_PLAIN;
                if (c == esd_pkg::CH_NUL)
                    end_string();
                else if (style_bit == STYLE_C && c == esd_pkg::CH_BSL)
                    dec_phase = esd_pkg::PH_BSL;
                else if (style_bit == STYLE_PCT && c == esd_pkg::CH_PCT)
                    dec_phase = esd_pkg::PH_PC1;
                else
                    put(c);
            end
        endcase
        for (int i = 0; i < run_buf.size(); i++)
            decoded_q.push_back('{data: run_buf[i], last: (i == run_buf.size() - 1)});
    endtask

    // ---------------------------------------------------------------
    // Source driver: accept at rising edge, update drive at falling edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            unescape_byte(s_axis_tdata);
            fed_cnt++;
            byte_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (byte_taken)
        begin
            void'(string_q.pop_front());
            byte_taken = 1'b0;
            presenting = 1'b0;
        end
        // valid stays up once raised; gaps only open between items
        if (!presenting && rst_n && string_q.size() > 0 &&
            (steady || $urandom_range(0, 99) >= IDLE_PCT))
            presenting = 1'b1;
        s_axis_tvalid <= presenting;
        s_axis_tdata  <= presenting ? string_q[0] : 8'($urandom);
    end

    // Sink back-pressure
    always @(negedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ---------------------------------------------------------------
    // Output monitor
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        dec_byte_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            out_cnt++;
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, actual data %02h last %0b",
                         $time, m_axis_tdata, m_axis_tlast);
                err_cnt++;
            end
            else
            begin
                want = decoded_q.pop_front();
                if (m_axis_tdata !== want.data)
                begin
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, want.data, m_axis_tdata);
                    err_cnt++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: run_last mismatch: expected %0b, actual %0b",
                             $time, want.last, m_axis_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d source bytes and %0d decoded bytes outstanding",
                     $time, string_q.size(), decoded_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b);
        string_q.push_back(b);
        queued_cnt++;
    endtask

    task automatic queue_intro(input logic pct);
        if (pct)
            queue_byte(esd_pkg::CH_PCT);
        else
        begin
            queue_byte(esd_pkg::CH_BSL);
            queue_byte(esd_pkg::CH_X);
        end
    endtask

    function automatic logic [7:0] rand_hex();
        int unsigned k;
        k = $urandom_range(0, 21);
        if (k < 10)
            return 8'h30 + 8'(k);
        if (k < 16)
            return 8'h41 + 8'(k - 10);
        return 8'h61 + 8'(k - 16);
    endfunction

    // Nonzero byte that is not a hex digit
    function automatic logic [7:0] rand_non_hex();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (is_hex(b));
        return b;
    endfunction

    // One random token: a plain byte, a well-formed escape, or a malformed or cut-off escape
    task automatic queue_token(input logic pct);
        int unsigned k;
        logic [7:0]  simple_ch [11];
        simple_ch = '{8'h27, 8'h22, 8'h3F, 8'h5C, 8'h61, 8'h62,
                      8'h66, 8'h6E, 8'h72, 8'h74, 8'h76};
        k = $urandom_range(0, 99);
        if (k < 28)
            queue_byte(8'($urandom_range(1, 255)));
        else if (k < 46)
        begin
            if (!pct)
                queue_byte(esd_pkg::CH_BSL);
            queue_byte(simple_ch[$urandom_range(0, 10)]);
        end
        else if (k < 68)
        begin
            queue_intro(pct);
            if ($urandom_range(0, 9) == 0)
            begin
                queue_byte(esd_pkg::CH_ZERO);
                queue_byte(esd_pkg::CH_ZERO);
            end
            else
            begin
                queue_byte(rand_hex());
                queue_byte(rand_hex());
            end
        end
        else if (k < 76)
        begin
            // bad second digit, sometimes the terminator
            queue_intro(pct);
            queue_byte(rand_hex());
            queue_byte($urandom_range(0, 3) == 0 ? esd_pkg::CH_NUL : rand_non_hex());
        end
        else if (k < 82)
        begin
            queue_intro(pct);
            queue_byte(rand_non_hex());
            queue_byte(8'($urandom_range(0, 255)));
        end
        else if (k < 88)
        begin
            queue_byte(pct ? esd_pkg::CH_PCT : esd_pkg::CH_BSL);
            queue_byte(8'($urandom_range(1, 255)));
        end
        else if (k < 94)
            queue_byte(esd_pkg::CH_NUL);
        else
        begin
            // string cut off inside an escape
            case ($urandom_range(0, 2))
                0: queue_byte(pct ? esd_pkg::CH_PCT : esd_pkg::CH_BSL);
                1: queue_intro(pct);
                default:
                begin
                    queue_intro(pct);
                    queue_byte(rand_hex());
                end
            endcase
            queue_byte(esd_pkg::CH_NUL);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (string_q.size() != 0 || decoded_q.size() != 0)
            @(negedge clk);
    endtask

    // Style write once idle; an opened escape may still be in flight
    task automatic write_style(input logic v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        style_bit = v;
        cfg_cnt++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic        phase_style [4];
        int unsigned start_cnt;
        phase_style = '{STYLE_C, STYLE_PCT, STYLE_C, STYLE_PCT};

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed, C style from reset
        queue_byte(8'hFF);
        queue_byte(esd_pkg::CH_BSL); queue_byte(8'h6E);             // \n
        queue_byte(esd_pkg::CH_BSL); queue_byte(8'h71);             // unknown \q
        queue_intro(STYLE_C);                                       // \x00
        queue_byte(esd_pkg::CH_ZERO); queue_byte(esd_pkg::CH_ZERO);
        queue_intro(STYLE_C);                                       // bad first, end
        queue_byte(8'h67); queue_byte(esd_pkg::CH_NUL);
        queue_intro(STYLE_C); queue_byte(8'h41); queue_byte(8'h7A); // bad second
        queue_byte(esd_pkg::CH_BSL); queue_byte(esd_pkg::CH_NUL);   // backslash at end
        queue_byte(esd_pkg::CH_BSL);                                // left open

        // Switch style with the escape still open: it completes as C
        write_style(STYLE_PCT);
        queue_byte(8'h6E);
        queue_byte(esd_pkg::CH_PCT); queue_byte(8'h34);             // ends mid escape
        queue_byte(esd_pkg::CH_NUL);
        queue_byte(esd_pkg::CH_PCT); queue_byte(8'h71);             // bad first digit
        queue_byte(8'h37);
        queue_byte(esd_pkg::CH_NUL);

        // Random phases
        for (int p = 0; p < 4; p++)
        begin
            write_style(phase_style[p]);
            steady = (p == 2);
            start_cnt = queued_cnt;
            while (queued_cnt - start_cnt < PHASE_ITEMS)
            begin
                queue_token(phase_style[p]);
                // hold the source until every decoded byte is back
                if (p == 1 && queued_cnt - start_cnt >= PHASE_ITEMS / 2 &&
                    queued_cnt - start_cnt < PHASE_ITEMS / 2 + 4)
                begin
                    wait_drained();
                    start_cnt = start_cnt - 4;
                end
            end
        end

        wait_drained();
        steady = 1'b0;
        repeat (4 * SETTLE_CYCLES) @(negedge clk);
        if (decoded_q.size() != 0)
        begin
            $display("%0t: %0d decoded bytes never arrived", $time, decoded_q.size());
            err_cnt++;
        end

        $display("Fed %0d source bytes in C and percent styles (%0d style writes), got %0d",
                 fed_cnt, cfg_cnt, out_cnt);
        $display("decoded bytes; %0d errors", err_cnt);
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
